// ===== rtl/core/m4xf_pkg.sv =====
// ----------------------------------------------------------------------------
// m4xf_pkg: shared types and constants for the 4x4 matrix by vector transform
// Element widths, sum widths, opcode codes and the control word that travels
// down the chain of column cells.
// ----------------------------------------------------------------------------
package m4xf_pkg;

   // matrix and vector dimension
   localparam int N_DIM  = 4;
   localparam int IDX_W  = 4;
   localparam int COL_W  = 2;

   // element and accumulator widths (elements are fixed 32-bit Q16.16)
   localparam int ELEM_W = 32;
   localparam int PROD_W = 2 * ELEM_W;
   localparam int SUM_W  = PROD_W + 2;

   // defaults for the top-level parameters
   localparam int DEF_FRAC_BITS  = 16;
   localparam int DEF_DATA_WIDTH = 32;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_XFORM = 1'b1
   } opcode_type;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   // control word handed from cell to cell
   typedef struct packed {
      logic             valid;
      logic             is_load;
      logic [IDX_W-1:0] index;
      elem_type         value;
   } ctl_type;

endpackage

// ===== rtl/core/m4xf_ifs.sv =====
// ----------------------------------------------------------------------------
// m4xf request and response channels
// Valid/ready channels; a word moves on a rising edge with valid and ready high.
// ----------------------------------------------------------------------------
interface m4xf_req_if;
   import m4xf_pkg::*;

   logic             valid;
   logic             ready;
   logic             opcode;
   logic [IDX_W-1:0] elem_index;
   elem_type         elem_value;
   elem_type         vec_x;
   elem_type         vec_y;
   elem_type         vec_z;
   elem_type         vec_w;

   modport source (
      output valid, opcode, elem_index, elem_value, vec_x, vec_y, vec_z, vec_w,
      input  ready
   );
   modport sink (
      input  valid, opcode, elem_index, elem_value, vec_x, vec_y, vec_z, vec_w,
      output ready
   );
endinterface

interface m4xf_rsp_if #(
   parameter int DATA_WIDTH = m4xf_pkg::DEF_DATA_WIDTH
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] out_x;
   logic signed [DATA_WIDTH-1:0] out_y;
   logic signed [DATA_WIDTH-1:0] out_z;
   logic signed [DATA_WIDTH-1:0] out_w;
   logic                         saturated;

   modport source (
      output valid, out_x, out_y, out_z, out_w, saturated,
      input  ready
   );
   modport sink (
      input  valid, out_x, out_y, out_z, out_w, saturated,
      output ready
   );
endinterface

// ===== rtl/core/m4xf_cell.sv =====
// ----------------------------------------------------------------------------
// m4xf_cell: one matrix column of the transform chain
// Holds column COL of the matrix, multiplies it by vector component COL and
// adds the four products to the partial row sums coming from the left.
// Loads for this column are written as they pass, keeping word order.
// ----------------------------------------------------------------------------
module m4xf_cell #(
   parameter int COL       = 0,
   parameter int FRAC_BITS = m4xf_pkg::DEF_FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  m4xf_pkg::ctl_type ctl_in,
   input  m4xf_pkg::elem_type vec_in  [m4xf_pkg::N_DIM],
   input  m4xf_pkg::sum_type  psum_in [m4xf_pkg::N_DIM],
   output m4xf_pkg::ctl_type ctl_out,
   output m4xf_pkg::elem_type vec_out  [m4xf_pkg::N_DIM],
   output m4xf_pkg::sum_type  psum_out [m4xf_pkg::N_DIM]
);
   import m4xf_pkg::*;

   localparam logic [ELEM_W-1:0] ONE_VAL = ELEM_W'(1) << FRAC_BITS;

   // column storage, row r at col_ff[r]
   logic [N_DIM-1:0][ELEM_W-1:0] col_ff;
   logic                         wr_en;

   // product stage
   ctl_type  ctl_p_ff;
   elem_type vec_p_ff  [N_DIM];
   sum_type  psum_p_ff [N_DIM];
   prod_type prod_ff   [N_DIM];
   prod_type prod_in   [N_DIM];

   // sum stage
   ctl_type  ctl_s_ff;
   elem_type vec_s_ff  [N_DIM];
   sum_type  psum_s_ff [N_DIM];
   sum_type  psum_s_in [N_DIM];

   assign wr_en = adv && ctl_in.valid && ctl_in.is_load &&
                  (ctl_in.index[COL_W-1:0] == COL_W'(COL));

   // column element write / identity reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < N_DIM; r++) begin
            col_ff[r] <= (r == COL) ? ONE_VAL : '0;
         end
      end else if (wr_en) begin
         col_ff[ctl_in.index[IDX_W-1:COL_W]] <= ctl_in.value;
      end
   end

   // one 32x32 product per row
   always_comb begin
      for (int r = 0; r < N_DIM; r++) begin
         prod_in[r] = PROD_W'(signed'(col_ff[r])) * PROD_W'(vec_in[COL]);
      end
   end

   // row sums
   always_comb begin
      for (int r = 0; r < N_DIM; r++) begin
         psum_s_in[r] = psum_p_ff[r] + SUM_W'(prod_ff[r]);
      end
   end

   // control words; only the valid bits are reset
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_p_ff.valid <= 1'b0;
         ctl_s_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl_p_ff <= ctl_in;
         ctl_s_ff <= ctl_p_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         vec_p_ff  <= vec_in;
         psum_p_ff <= psum_in;
         prod_ff   <= prod_in;
         vec_s_ff  <= vec_p_ff;
         psum_s_ff <= psum_s_in;
      end
   end

   assign ctl_out  = ctl_s_ff;
   assign vec_out  = vec_s_ff;
   assign psum_out = psum_s_ff;

   // column only changes on a load addressed to it
   a_col_hold: assert property (@(posedge clock) disable iff (reset)
      !wr_en |=> $stable(col_ff))
      else $error("column storage changed without a load");

   // a stalled chain keeps its control words
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(ctl_s_ff) && $stable(ctl_p_ff)))
      else $error("cell advanced during stall");

endmodule

// ===== rtl/core/m4xf_finish.sv =====
// ----------------------------------------------------------------------------
// m4xf_finish: scaling, saturation and output register
// Shifts each row sum right by FRAC_BITS, clamps to DATA_WIDTH bits and holds
// the result word until the sink takes it. Load words are dropped here.
// ----------------------------------------------------------------------------
module m4xf_finish #(
   parameter int FRAC_BITS  = m4xf_pkg::DEF_FRAC_BITS,
   parameter int DATA_WIDTH = m4xf_pkg::DEF_DATA_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  m4xf_pkg::ctl_type ctl_in,
   input  m4xf_pkg::sum_type sum_in [m4xf_pkg::N_DIM],
   output logic              adv,
   m4xf_rsp_if.source        rsp_ch
);
   import m4xf_pkg::*;

   localparam int SH_W  = SUM_W - FRAC_BITS;
   localparam int EXT_W = (SH_W > DATA_WIDTH) ? SH_W : DATA_WIDTH;
   localparam int HI_W  = EXT_W - DATA_WIDTH + 1;

   localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic signed [SH_W-1:0]       sh     [N_DIM];
   logic signed [EXT_W-1:0]      ext    [N_DIM];
   logic [HI_W-1:0]              hi_bits[N_DIM];
   logic [N_DIM-1:0]             clamp;
   logic signed [DATA_WIDTH-1:0] res_in [N_DIM];

   logic                         valid_ff;
   logic signed [DATA_WIDTH-1:0] out_ff [N_DIM];
   logic                         sat_ff;

   // floor shift, then clamp when the sign bit and the bits above it are not all equal
   always_comb begin
      for (int r = 0; r < N_DIM; r++) begin
         sh[r]      = sum_in[r][SUM_W-1:FRAC_BITS];
         ext[r]     = EXT_W'(sh[r]);
         hi_bits[r] = ext[r][EXT_W-1:DATA_WIDTH-1];
         clamp[r]   = !((&hi_bits[r]) || !(|hi_bits[r]));
         if (clamp[r]) begin
            res_in[r] = ext[r][EXT_W-1] ? SAT_MIN : SAT_MAX;
         end else begin
            res_in[r] = ext[r][DATA_WIDTH-1:0];
         end
      end
   end

   // whole chain moves when the output register is free or being read
   assign adv = !valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= ctl_in.valid && !ctl_in.is_load;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= res_in;
         sat_ff <= |clamp;
      end
   end

   assign rsp_ch.valid     = valid_ff;
   assign rsp_ch.out_x     = out_ff[0];
   assign rsp_ch.out_y     = out_ff[1];
   assign rsp_ch.out_z     = out_ff[2];
   assign rsp_ch.out_w     = out_ff[3];
   assign rsp_ch.saturated = sat_ff;

   // a flagged word carries at least one clamped component
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && sat_ff) |->
         (out_ff[0] == SAT_MAX || out_ff[0] == SAT_MIN ||
          out_ff[1] == SAT_MAX || out_ff[1] == SAT_MIN ||
          out_ff[2] == SAT_MAX || out_ff[2] == SAT_MIN ||
          out_ff[3] == SAT_MAX || out_ff[3] == SAT_MIN))
      else $error("saturated flag without a clamped component");

   // load words never reach the response channel
   a_load_drop: assert property (@(posedge clock) disable iff (reset)
      (adv && ctl_in.valid && ctl_in.is_load) |=> !valid_ff)
      else $error("load word produced a response");

endmodule

// ===== rtl/core/mat4_vec4_transform_top.sv =====
// ----------------------------------------------------------------------------
// mat4_vec4_transform_top: 4x4 matrix by 4-vector transform, Q16.16
// Pipeline: a transform word passes two stages per column cell in four cells
// and then one output register before it shows on rsp.
// Throughput: one word per cycle; the chain stalls only while rsp is held.
// Reset: synchronous; empties the chain and loads the identity matrix.
// ----------------------------------------------------------------------------
module mat4_vec4_transform_top #(
   parameter int FRAC_BITS  = m4xf_pkg::DEF_FRAC_BITS,
   parameter int DATA_WIDTH = m4xf_pkg::DEF_DATA_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   m4xf_req_if.sink   req_ch,
   m4xf_rsp_if.source rsp_ch
);
   import m4xf_pkg::*;

   logic     adv;
   ctl_type  ctl_c  [N_DIM+1];
   elem_type vec_c  [N_DIM+1][N_DIM];
   sum_type  psum_c [N_DIM+1][N_DIM];

   // request word enters the first cell
   always_comb begin
      ctl_c[0].valid   = req_ch.valid;
      ctl_c[0].is_load = (req_ch.opcode == OP_LOAD);
      ctl_c[0].index   = req_ch.elem_index;
      ctl_c[0].value   = req_ch.elem_value;
      vec_c[0][0]      = req_ch.vec_x;
      vec_c[0][1]      = req_ch.vec_y;
      vec_c[0][2]      = req_ch.vec_z;
      vec_c[0][3]      = req_ch.vec_w;
      for (int r = 0; r < N_DIM; r++) begin
         psum_c[0][r] = '0;
      end
   end

   assign req_ch.ready = adv;

   // chain of column cells
   for (genvar c = 0; c < N_DIM; c++) begin : g_cell
      m4xf_cell #(
         .COL       (c),
         .FRAC_BITS (FRAC_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .ctl_in   (ctl_c[c]),
         .vec_in   (vec_c[c]),
         .psum_in  (psum_c[c]),
         .ctl_out  (ctl_c[c+1]),
         .vec_out  (vec_c[c+1]),
         .psum_out (psum_c[c+1])
      );
   end

   // scale, clamp and hold the result word
   m4xf_finish #(
      .FRAC_BITS  (FRAC_BITS),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_finish (
      .clock  (clock),
      .reset  (reset),
      .ctl_in (ctl_c[N_DIM]),
      .sum_in (psum_c[N_DIM]),
      .adv    (adv),
      .rsp_ch (rsp_ch)
   );

endmodule

// ===== sim/mat4_vec4_transform_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mat4_vec4_transform_checker: predicts and checks transformed vertices
// Watches the request and response channels. It keeps its own copy of the
// 4x4 coefficient matrix and queues one predicted vertex per accepted
// transform word. Each response word is compared against the oldest one.
// ----------------------------------------------------------------------------
module mat4_vec4_transform_checker #(
   parameter int FRAC_BITS  = m4xf_pkg::DEF_FRAC_BITS,
   parameter int DATA_WIDTH = m4xf_pkg::DEF_DATA_WIDTH
) (
   input  logic  clock,
   input  logic  reset,
   m4xf_req_if   req_ch,
   m4xf_rsp_if   rsp_ch,
   output int    fail_count,
   output int    pending,
   output int    checked_vertices,
   output int    clamped_vertices
);
   import m4xf_pkg::*;

   // row sums need 66 bits plus headroom for the shift
   localparam int ACC_W       = 96;
   localparam int MAX_REPORTS = 40;

   typedef logic signed [ACC_W-1:0]      acc_type;
   typedef logic signed [DATA_WIDTH-1:0] comp_type;

   typedef struct {
      comp_type x;
      comp_type y;
      comp_type z;
      comp_type w;
      logic     sat;
   } vertex_type;

   localparam acc_type SUM_MAX = (acc_type'(1) <<< (DATA_WIDTH-1)) - acc_type'(1);
   localparam acc_type SUM_MIN = -(acc_type'(1) <<< (DATA_WIDTH-1));

   elem_type   coef [16];
   vertex_type xformed_vertex_q [$];
   int         errors   = 0;
   int         reports  = 0;
   int         checked  = 0;
   int         clamped  = 0;

   // one matrix row dotted with the vector: exact sum, floor shift, clamp
   function automatic comp_type row_dot(input int row, input elem_type vx, input elem_type vy,
                                        input elem_type vz, input elem_type vw,
                                        inout logic clamp);
      acc_type sum;
      sum = acc_type'(coef[row*4])   * acc_type'(vx)
          + acc_type'(coef[row*4+1]) * acc_type'(vy)
          + acc_type'(coef[row*4+2]) * acc_type'(vz)
          + acc_type'(coef[row*4+3]) * acc_type'(vw);
      sum = sum >>> FRAC_BITS;
      if (sum > SUM_MAX) begin
         clamp = 1'b1;
         return SUM_MAX[DATA_WIDTH-1:0];
      end
      if (sum < SUM_MIN) begin
         clamp = 1'b1;
         return SUM_MIN[DATA_WIDTH-1:0];
      end
      return sum[DATA_WIDTH-1:0];
   endfunction

   function automatic vertex_type transform_vertex(input elem_type vx, input elem_type vy,
                                                   input elem_type vz, input elem_type vw);
      vertex_type v;
      logic       clamp;
      clamp = 1'b0;
      v.x   = row_dot(0, vx, vy, vz, vw, clamp);
      v.y   = row_dot(1, vx, vy, vz, vw, clamp);
      v.z   = row_dot(2, vx, vy, vz, vw, clamp);
      v.w   = row_dot(3, vx, vy, vz, vw, clamp);
      v.sat = clamp;
      return v;
   endfunction

   // every mismatching field is counted and reported
   task automatic compare_field(input string name, input comp_type want, input comp_type got);
      if (want !== got) begin
         errors++;
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
      end
   endtask

   // monitor: responses are checked first, then the request updates the model
   always @(posedge clock) begin
      vertex_type want;
      if (reset) begin
         for (int i = 0; i < 16; i++)
            coef[i] = (i % 5 == 0) ? (elem_type'(1) <<< FRAC_BITS) : elem_type'(0);
         xformed_vertex_q.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (xformed_vertex_q.size() == 0) begin
               errors++;
               if (reports < MAX_REPORTS) begin
                  reports++;
                  $error("response word with no transform outstanding");
               end
            end else begin
               want = xformed_vertex_q.pop_front();
               compare_field("out_x", want.x, rsp_ch.out_x);
               compare_field("out_y", want.y, rsp_ch.out_y);
               compare_field("out_z", want.z, rsp_ch.out_z);
               compare_field("out_w", want.w, rsp_ch.out_w);
               compare_field("saturated", comp_type'(want.sat), comp_type'(rsp_ch.saturated));
               checked++;
               if (want.sat)
                  clamped++;
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.opcode == OP_LOAD)
               coef[req_ch.elem_index] = req_ch.elem_value;
            else
               xformed_vertex_q.push_back(transform_vertex(req_ch.vec_x, req_ch.vec_y,
                                                           req_ch.vec_z, req_ch.vec_w));
         end
      end
      fail_count       <= errors;
      pending          <= xformed_vertex_q.size();
      checked_vertices <= checked;
      clamped_vertices <= clamped;
   end

endmodule

// ===== sim/mat4_vec4_transform_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mat4_vec4_transform_top_tb: testbench for the 4x4 matrix by vector transform
// Drives element loads and vertex transforms in bursts against a stalling
// receiver, with one long receiver hold-off that backs up the pipeline. The
// checker beside the block does all prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module mat4_vec4_transform_top_tb;
   import m4xf_pkg::*;

   localparam int FRAC_BITS      = DEF_FRAC_BITS;
   localparam int DATA_WIDTH     = DEF_DATA_WIDTH;
   localparam int RANDOM_WORDS   = 1700;
   localparam int HOLD_AFTER     = 400;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 16;

   localparam elem_type Q_ONE  = 32'sh0001_0000;
   localparam elem_type Q_HALF = 32'sh0000_8000;
   localparam elem_type Q_MAX  = 32'sh7FFF_FFFF;
   localparam elem_type Q_MIN  = 32'sh8000_0000;
   localparam elem_type Q_NULP = -32'sd1;

   typedef enum int {
      RX_ALWAYS,
      RX_RANDOM,
      RX_PATTERN,
      RX_SPARSE
   } rx_mode_type;

   logic clock;
   logic reset;

   int   fail_count;
   int   pending;
   int   checked_vertices;
   int   clamped_vertices;
   int   words_sent  = 0;
   int   load_words  = 0;
   int   burst_left  = 0;
   int   idle_cycles = 0;

   m4xf_req_if                          req_ch ();
   m4xf_rsp_if #(.DATA_WIDTH(DATA_WIDTH)) rsp_ch ();

   mat4_vec4_transform_top #(
      .FRAC_BITS  (FRAC_BITS),
      .DATA_WIDTH (DATA_WIDTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   mat4_vec4_transform_checker #(
      .FRAC_BITS  (FRAC_BITS),
      .DATA_WIDTH (DATA_WIDTH)
   ) checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .fail_count       (fail_count),
      .pending          (pending),
      .checked_vertices (checked_vertices),
      .clamped_vertices (clamped_vertices)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Q16.16 operand mix: mostly small values, some full range and edge values
   function automatic elem_type pick_q();
      elem_type q;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: q = elem_type'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
         5, 6:          q = elem_type'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
         7, 8:          q = elem_type'($urandom);
         default: begin
            case ($urandom_range(0, 4))
               0:       q = Q_MAX;
               1:       q = Q_MIN;
               2:       q = elem_type'(0);
               3:       q = Q_NULP;
               default: q = Q_ONE;
            endcase
         end
      endcase
      return q;
   endfunction

   // offer one word; a new burst may start with a random gap of valid low
   task automatic send_word(input opcode_type op, input logic [IDX_W-1:0] idx,
                            input elem_type val, input elem_type vx, input elem_type vy,
                            input elem_type vz, input elem_type vw);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 12);
      end
      req_ch.valid      <= 1'b1;
      req_ch.opcode     <= op;
      req_ch.elem_index <= idx;
      req_ch.elem_value <= val;
      req_ch.vec_x      <= vx;
      req_ch.vec_y      <= vy;
      req_ch.vec_z      <= vz;
      req_ch.vec_w      <= vw;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      burst_left--;
      words_sent++;
   endtask

   // vector fields carry noise on loads
   task automatic load_elem(input logic [IDX_W-1:0] idx, input elem_type val);
      send_word(OP_LOAD, idx, val, elem_type'($urandom), elem_type'($urandom),
                elem_type'($urandom), elem_type'($urandom));
      load_words++;
   endtask

   // element fields carry noise on transforms
   task automatic xform_vec(input elem_type vx, input elem_type vy,
                            input elem_type vz, input elem_type vw);
      send_word(OP_XFORM, IDX_W'($urandom_range(0, 15)), elem_type'($urandom),
                vx, vy, vz, vw);
   endtask

   // stimulus
   initial begin
      int target;
      int n_loads;
      int n_vecs;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.opcode     <= OP_LOAD;
      req_ch.elem_index <= '0;
      req_ch.elem_value <= '0;
      req_ch.vec_x      <= '0;
      req_ch.vec_y      <= '0;
      req_ch.vec_z      <= '0;
      req_ch.vec_w      <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // identity matrix straight out of reset
      xform_vec(Q_ONE, -Q_ONE, Q_MAX, Q_MIN);
      xform_vec(elem_type'(0), elem_type'(0), elem_type'(0), elem_type'(0));
      // extreme rows: overflow in both directions
      for (int k = 0; k < 4; k++)
         load_elem(IDX_W'(k), Q_MAX);
      for (int k = 4; k < 8; k++)
         load_elem(IDX_W'(k), Q_MIN);
      xform_vec(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      xform_vec(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
      xform_vec(Q_MIN, Q_MAX, Q_MIN, Q_MAX);
      // negative fractions round toward minus infinity
      load_elem(IDX_W'(10), Q_HALF);
      load_elem(IDX_W'(15), Q_NULP);
      xform_vec(Q_ONE, Q_ONE, Q_NULP, Q_ONE);
      xform_vec(Q_NULP, Q_NULP, Q_HALF, Q_NULP);

      // random batches: load some coefficients, then stream vertices; now and then a single load or transform instead
      target = words_sent + RANDOM_WORDS;
      while (words_sent < target) begin
         if ($urandom_range(0, 7) == 0) begin
            if ($urandom_range(0, 1) == 0)
               load_elem(IDX_W'($urandom_range(0, 15)), pick_q());
            else
               xform_vec(elem_type'($urandom), elem_type'($urandom),
                         elem_type'($urandom), elem_type'($urandom));
         end else begin
            n_loads = $urandom_range(0, 16);
            if (n_loads == 16) begin
               for (int k = 0; k < 16; k++)
                  load_elem(IDX_W'(k), pick_q());
            end else begin
               repeat (n_loads) load_elem(IDX_W'($urandom_range(0, 15)), pick_q());
            end
            n_vecs = $urandom_range(4, 40);
            repeat (n_vecs) xform_vec(pick_q(), pick_q(), pick_q(), pick_q());
         end
      end
      req_ch.valid <= 1'b0;

      // drain: wait for every vertex, then let the clock run on for DRAIN_CYCLES
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d words: %0d element loads, %0d vertex transforms.",
               words_sent, load_words, words_sent - load_words);
      $display("Checked %0d transformed vertices, %0d of them clamped.",
               checked_vertices, clamped_vertices);
      if (pending != 0)
         $error("%0d transformed vertices never arrived", pending);
      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // receiver: segments of different stall patterns plus one long hold-off
   initial begin
      bit          long_hold_done;
      rx_mode_type mode;
      int          seg_len;
      long_hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         if (!long_hold_done && words_sent >= HOLD_AFTER) begin
            @(posedge clock);
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold_done = 1'b1;
         end
         mode    = rx_mode_type'($urandom_range(0, 3));
         seg_len = $urandom_range(20, 200);
         for (int i = 0; i < seg_len; i++) begin
            @(posedge clock);
            case (mode)
               RX_ALWAYS:  rsp_ch.ready <= 1'b1;
               RX_RANDOM:  rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               RX_PATTERN: rsp_ch.ready <= ((i % 5) < 3);
               default:    rsp_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // watchdog: ends the run when neither channel moves a word for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no word moved for %0d cycles.", idle_cycles);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
